// ===== rtl/core/tsvs_pkg.sv =====
package tsvs_pkg;

   localparam int MaxBins = 16384;
   localparam int IdxW = $clog2(MaxBins);
   localparam int CntW = IdxW + 1;

   localparam logic KIND_BIN  = 1'b0;
   localparam logic KIND_READ = 1'b1;

   localparam logic [1:0] CFG_P01 = 2'd0;
   localparam logic [1:0] CFG_P02 = 2'd1;
   localparam logic [1:0] CFG_P12 = 2'd2;

   typedef struct packed {
      logic [13:0] p01;
      logic [13:0] p02;
      logic [13:0] p12;
   } penalty_type;

   typedef struct packed {
      logic [31:0] total;
      logic [1:0]  ptr;
   } lane_out_type;

   function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
      logic [32:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[32] ? 32'hFFFF_FFFF : s[31:0];
   endfunction

   function automatic logic [13:0] sw_cost(input logic [1:0] f, input logic [1:0] t,
                                           input penalty_type p);
      logic [1:0] o;
      o = f | t;
      if (f == t) return 14'd0;
      if (o == 2'd1) return p.p01;
      if (o == 2'd2) return p.p02;
      return p.p12;
   endfunction

endpackage

// ===== rtl/core/tsvs_lane.sv =====
// One add-compare-select lane for a fixed target state.
module tsvs_lane (
   input  logic [1:0]               lane_state,
   input  logic [31:0]              prev_cost [3],
   input  tsvs_pkg::penalty_type    pen,
   input  logic [15:0]              own_cost,
   output tsvs_pkg::lane_out_type   lane_out
);
   logic [31:0] c0, c1, c2, best;
   logic [1:0]  bi;

   always_comb begin
      c0 = tsvs_pkg::sat_add(prev_cost[0], {18'd0, tsvs_pkg::sw_cost(2'd0, lane_state, pen)});
      c1 = tsvs_pkg::sat_add(prev_cost[1], {18'd0, tsvs_pkg::sw_cost(2'd1, lane_state, pen)});
      c2 = tsvs_pkg::sat_add(prev_cost[2], {18'd0, tsvs_pkg::sw_cost(2'd2, lane_state, pen)});
      best = c0;
      bi = 2'd0;
      if (c1 < best) begin
         best = c1;
         bi = 2'd1;
      end
      if (c2 < best) begin
         best = c2;
         bi = 2'd2;
      end
      lane_out.total = tsvs_pkg::sat_add(best, {16'd0, own_cost});
      lane_out.ptr = bi;
   end
endmodule

// ===== rtl/core/three_state_viterbi_segmenter.sv =====
// Channel   Dir  Fields (tdata low bit up)
// req_      in   tdata: cost_state_zero, cost_state_one, cost_state_two, read_index
//                tuser: kind; tlast: last_bin
// rsp_      out  tdata: bin_number,total_zero..two,end_state,count_zero..two,path_state
//                tuser: error_flag
// csr_      in   write enable, index, 14-bit data
// A bin item is accepted and its result registered. A last bin adds a traceback over
// each stored bin (wait for the registered back pointer memory read, then step). A
// read item waits through states ST_RD and ST_RD2 for the path memory read.
// Reset is synchronous; stores are not cleared. The result register holds until taken.
module three_state_viterbi_segmenter (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // cost0[15:0], cost1[31:16], cost2[47:32], read_index[61:48]
   input  logic         req_tuser,   // kind
   input  logic         req_tlast,   // last_bin
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // bin_number, total0..2, end_state, count0..2, path_state
   output logic         rsp_tuser,   // error_flag
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [13:0]  csr_wdata
);
   localparam int IW = tsvs_pkg::IdxW;
   localparam int CW = tsvs_pkg::CntW;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_TB   = 3'd1;
   localparam logic [2:0] ST_RD   = 3'd2;
   localparam logic [2:0] ST_RD2  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;
   localparam logic [2:0] ST_TBW  = 3'd5;

   tsvs_pkg::penalty_type pen_ff;
   logic [2:0]  state_ff;
   logic [31:0] cost_ff [3];
   logic [31:0] next_cost [3];
   logic [CW-1:0] bcnt_ff, rlen_ff;
   logic [5:0]  bp_mem [tsvs_pkg::MaxBins];
   logic [1:0]  path_mem [tsvs_pkg::MaxBins];
   tsvs_pkg::lane_out_type lane_res [3];

   logic [IW-1:0] tb_idx_ff;
   logic [1:0]    cur_ff;
   logic [5:0]    bp_rd_ff;
   logic [1:0]    path_rd_ff;
   logic [CW-1:0] cnt_ff [3];
   logic          rd_err_ff;

   logic [IW-1:0] o_bin_ff;
   logic [31:0]   o_tot_ff [3];
   logic [1:0]    o_fin_ff, o_path_ff;
   logic          o_err_ff, o_valid_ff;

   logic [15:0] in_cost [3];
   logic [IW-1:0] rd_idx;
   logic accept, full;
   logic [1:0] best_fin;
   logic [1:0] prev_st;

   assign in_cost[0] = req_tdata[15:0];
   assign in_cost[1] = req_tdata[31:16];
   assign in_cost[2] = req_tdata[47:32];
   assign rd_idx = req_tdata[48 +: IW];
   assign req_tready = (state_ff == ST_IDLE) && !o_valid_ff;
   assign accept = req_tvalid && req_tready;
   assign full = bcnt_ff == CW'(tsvs_pkg::MaxBins);

   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_lane
         tsvs_lane u_lane (
            .lane_state(2'(g)), .prev_cost(cost_ff), .pen(pen_ff),
            .own_cost(in_cost[g]), .lane_out(lane_res[g]));
      end
   endgenerate

   // merge stage: new totals (held when full), first bin takes raw costs
   always_comb begin
      for (int s = 0; s < 3; s++) begin
         if (full) next_cost[s] = cost_ff[s];
         else if (bcnt_ff == '0) next_cost[s] = {16'd0, in_cost[s]};
         else next_cost[s] = lane_res[s].total;
      end
      best_fin = 2'd0;
      if (next_cost[1] < next_cost[0]) best_fin = 2'd1;
      if (next_cost[2] < next_cost[best_fin]) best_fin = 2'd2;
      prev_st = bp_rd_ff[2*cur_ff +: 2];
      if (prev_st == 2'd3) prev_st = 2'd0;
   end

   always_ff @(posedge clock) begin
      bp_rd_ff <= bp_mem[tb_idx_ff];
      // path entry is captured with the read transfer and held until the result
      if (accept) path_rd_ff <= path_mem[rd_idx];
      if (accept && req_tuser == tsvs_pkg::KIND_BIN && !full)
         bp_mem[bcnt_ff[IW-1:0]] <= {lane_res[2].ptr, lane_res[1].ptr, lane_res[0].ptr};
      if (reset) begin
         pen_ff <= '{p01: 14'd2551, p02: 14'd5102, p12: 14'd2551};
         state_ff <= ST_IDLE;
         bcnt_ff <= '0;
         rlen_ff <= '0;
         o_valid_ff <= 1'b0;
         for (int s = 0; s < 3; s++) cost_ff[s] <= '0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               tsvs_pkg::CFG_P01: pen_ff.p01 <= csr_wdata;
               tsvs_pkg::CFG_P02: pen_ff.p02 <= csr_wdata;
               tsvs_pkg::CFG_P12: pen_ff.p12 <= csr_wdata;
               default: ;
            endcase
         end
         if (o_valid_ff && rsp_tready) o_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  for (int s = 0; s < 3; s++) cnt_ff[s] <= '0;
                  o_fin_ff <= 2'd0;
                  o_path_ff <= 2'd0;
                  if (req_tuser == tsvs_pkg::KIND_READ) begin
                     o_bin_ff <= rd_idx;
                     rd_err_ff <= {1'b0, rd_idx} >= rlen_ff;
                     for (int s = 0; s < 3; s++) o_tot_ff[s] <= '0;
                     state_ff <= ST_RD;
                  end else begin
                     o_bin_ff <= bcnt_ff[IW-1:0];
                     o_err_ff <= full;
                     for (int s = 0; s < 3; s++) begin
                        cost_ff[s] <= next_cost[s];
                        o_tot_ff[s] <= next_cost[s];
                     end
                     if (req_tlast) begin
                        o_fin_ff <= best_fin;
                        cur_ff <= best_fin;
                        rlen_ff <= full ? bcnt_ff : bcnt_ff + 1'b1;
                        tb_idx_ff <= full ? IW'(tsvs_pkg::MaxBins - 1) : bcnt_ff[IW-1:0];
                        bcnt_ff <= '0;
                        state_ff <= ST_TBW;
                     end else begin
                        if (!full) bcnt_ff <= bcnt_ff + 1'b1;
                        o_valid_ff <= 1'b1;
                     end
                  end
               end
            end
            ST_TBW: state_ff <= ST_TB; // wait for pointer read
            ST_TB: begin
               path_mem[tb_idx_ff] <= cur_ff;
               cnt_ff[cur_ff] <= cnt_ff[cur_ff] + 1'b1;
               if (tb_idx_ff == '0) begin
                  state_ff <= ST_OUT;
               end else begin
                  cur_ff <= prev_st;
                  tb_idx_ff <= tb_idx_ff - 1'b1;
                  state_ff <= ST_TBW;
               end
            end
            ST_OUT: begin
               o_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            ST_RD: state_ff <= ST_RD2;
            ST_RD2: begin
               o_err_ff <= rd_err_ff;
               o_path_ff <= rd_err_ff ? 2'd0 : path_rd_ff;
               o_valid_ff <= 1'b1;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tuser = o_err_ff;
   assign rsp_tdata = {1'b0, o_path_ff, cnt_ff[2], cnt_ff[1], cnt_ff[0], o_fin_ff,
                       o_tot_ff[2], o_tot_ff[1], o_tot_ff[0], o_bin_ff};
endmodule
